@@ sv/lei_pkg.sv @@
// Shared types and constants for the relativistic entity integrator.
// No dependencies; the top level and lei_fxmac import this package.
package lei_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned C2_W      = 63;
  localparam int unsigned CFG_IDX_W = 1;

  // Largest positive signed 64-bit value and the most negative one as raw bits.
  localparam logic [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C_SQUARED = 1'b0,
    CFG_TIME_STEP = 1'b1
  } cfg_idx_e;

endpackage

@@ sv/lorentz_entity_integrator_unit.sv @@
// Top level of the relativistic entity integrator: one entity in, one result out.
// Depends on lei_pkg, lei_fxmac, lei_div_cell, lei_sqrt_cell and lei_delay.
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  command | start_i, busy_o, pos/vel/proper_time/mass     | in
//  result  | done_o, new_pos_*, new_proper_time, eff. mass | out
//  config  | cfg_we_i, cfg_idx_i, cfg_wdata_i              | in
//
// One entity is taken every cycle; busy_o stays low, so every start_i pulse is
// a transfer. The pipeline depth is set by the length of the cell chains: the
// beta squared divider (FRAC_BITS cells), the square root (FRAC_BITS + 1
// cells) and the gamma reciprocal divider (2 * FRAC_BITS + 1 cells).
// Reset clears only the valid pipeline and sets the two configuration
// registers (c squared to one, the time step to zero). The receiver
// cannot stall, so done_o is a single-cycle strobe per result transfer.
module lorentz_entity_integrator_unit #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [lei_pkg::DATA_W-1:0]       pos_x_i,
  input  logic [lei_pkg::DATA_W-1:0]       pos_y_i,
  input  logic [lei_pkg::DATA_W-1:0]       pos_z_i,
  input  logic [lei_pkg::DATA_W-1:0]       vel_x_i,
  input  logic [lei_pkg::DATA_W-1:0]       vel_y_i,
  input  logic [lei_pkg::DATA_W-1:0]       vel_z_i,
  input  logic [lei_pkg::DATA_W-1:0]       proper_time_in_i,
  input  logic [lei_pkg::DATA_W-1:0]       rest_mass_i,
  output logic                             done_o,
  output logic [lei_pkg::DATA_W-1:0]       new_pos_x_o,
  output logic [lei_pkg::DATA_W-1:0]       new_pos_y_o,
  output logic [lei_pkg::DATA_W-1:0]       new_pos_z_o,
  output logic [lei_pkg::DATA_W-1:0]       new_proper_time_o,
  output logic [lei_pkg::DATA_W-1:0]       effective_mass_o,
  input  logic                             cfg_we_i,
  input  logic [lei_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lei_pkg::DATA_W-1:0]       cfg_wdata_i
);
  import lei_pkg::*;

  localparam int unsigned F       = FRAC_BITS;
  localparam int unsigned ROOT_W  = F + 1;
  localparam int unsigned RAD_W   = 2 * F + 2;
  localparam int unsigned GQ_W    = 2 * F + 1;
  localparam int unsigned GX_W    = (GQ_W > DATA_W) ? GQ_W : DATA_W;
  // Stage numbers count register edges after the input register.
  localparam int unsigned ST_PREP = 6;
  localparam int unsigned ST_RAD  = 7 + F;
  localparam int unsigned ST_ROOT = 8 + 2 * F;
  localparam int unsigned ST_MUL  = 10 + 4 * F;
  localparam int unsigned LAT     = 14 + 4 * F;

  localparam logic [ROOT_W-1:0] ONE_RAW   = ROOT_W'(1) << F;
  localparam logic [ROOT_W-1:0] BETA2_CAP = ONE_RAW - ROOT_W'(6);

  // Configuration registers; the user must write them only while no entity is in flight, the block does not enforce it.
  logic [C2_W-1:0]   c2_q;
  logic [DATA_W-1:0] ts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_q <= C2_W'(ONE_RAW);
      ts_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_C_SQUARED: c2_q <= cfg_wdata_i[C2_W-1:0];
        CFG_TIME_STEP: ts_q <= cfg_wdata_i;
        default:       c2_q <= c2_q;
      endcase
    end
  end

  // Valid bits follow each entity down the pipeline.
  logic          accept;
  logic [LAT:0]  vld_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-1:0], accept};
    end
  end

  assign done_o = vld_q[LAT];

  // Input register.
  logic [DATA_W-1:0] pos_q [3];
  logic [DATA_W-1:0] vel_q [3];
  logic [DATA_W-1:0] ptime_q, mass_q;

  always_ff @(posedge clk_i) begin
    pos_q[0] <= pos_x_i;
    pos_q[1] <= pos_y_i;
    pos_q[2] <= pos_z_i;
    vel_q[0] <= vel_x_i;
    vel_q[1] <= vel_y_i;
    vel_q[2] <= vel_z_i;
    ptime_q  <= proper_time_in_i;
    mass_q   <= rest_mass_i;
  end

  // Per axis: the position update and the squared speed component. A square
  // is never negative, so the multiplier's saturation already caps it at SMAX.
  logic [DATA_W-1:0] pos_new [3];
  logic [DATA_W-1:0] vel_sq  [3];
  logic [DATA_W-1:0] pos_out [3];

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    lei_fxmac #(.FRAC_BITS(F)) u_pos (
      .clk_i, .a_i(vel_q[ax]), .b_i(ts_q), .addend_i(pos_q[ax]), .sum_o(pos_new[ax])
    );
    lei_fxmac #(.FRAC_BITS(F)) u_sq (
      .clk_i, .a_i(vel_q[ax]), .b_i(vel_q[ax]), .addend_i('0), .sum_o(vel_sq[ax])
    );
    lei_delay #(.WIDTH(DATA_W), .DEPTH(LAT - 4)) u_pos_dly (
      .clk_i, .data_i(pos_new[ax]), .data_o(pos_out[ax])
    );
  end

  assign new_pos_x_o = pos_out[0];
  assign new_pos_y_o = pos_out[1];
  assign new_pos_z_o = pos_out[2];

  // Sum of squares, saturating at SMAX after each addition.
  logic [DATA_W:0]   sum01, sum012;
  logic [DATA_W-1:0] part01, v2_d, v2_q;

  assign sum01  = {1'b0, vel_sq[0]} + {1'b0, vel_sq[1]};
  assign part01 = (sum01 > (DATA_W+1)'(SMAX)) ? SMAX : sum01[DATA_W-1:0];
  assign sum012 = {1'b0, part01} + {1'b0, vel_sq[2]};
  assign v2_d   = (sum012 > (DATA_W+1)'(SMAX)) ? SMAX : sum012[DATA_W-1:0];

  always_ff @(posedge clk_i) begin
    v2_q <= v2_d;
  end

  // A speed at or beyond c, or a zero c squared, pins beta squared to the
  // clamp value; otherwise the divider starts with v^2 as its remainder.
  logic            clamp_d, clamp_q, clamp_late;
  logic [C2_W-1:0] brem0_q;

  assign clamp_d = (c2_q == '0) || (v2_q >= {1'b0, c2_q});

  always_ff @(posedge clk_i) begin
    clamp_q <= clamp_d;
    brem0_q <= clamp_d ? '0 : v2_q[C2_W-1:0];
  end

  lei_delay #(.WIDTH(1), .DEPTH(F)) u_clamp_dly (
    .clk_i, .data_i(clamp_q), .data_o(clamp_late)
  );

  // Beta squared divider: v^2 * 2^F / c^2, one quotient bit per cell.
  logic [C2_W-1:0] brem [F+1];
  logic [F-1:0]    bquo [F+1];
  logic [C2_W-1:0] bden [F+1];

  assign brem[0] = brem0_q;
  assign bquo[0] = '0;
  assign bden[0] = c2_q;

  for (genvar k = 0; k < F; k++) begin : g_bdiv
    lei_div_cell #(.DEN_W(C2_W), .QUO_W(F)) u_cell (
      .clk_i, .rem_i(brem[k]), .quo_i(bquo[k]), .den_i(bden[k]), .num_bit_i(1'b0),
      .rem_o(brem[k+1]), .quo_o(bquo[k+1]), .den_o(bden[k+1])
    );
  end

  // One minus beta squared, scaled up by 2^F to form the root's radicand.
  logic [ROOT_W-1:0] beta2, one_minus;
  logic [RAD_W-1:0]  rad_q;

  always_comb begin
    beta2 = ROOT_W'(bquo[F]);
    if (clamp_late || (beta2 > BETA2_CAP)) begin
      beta2 = BETA2_CAP;
    end
  end
  assign one_minus = ONE_RAW - beta2;

  always_ff @(posedge clk_i) begin
    rad_q <= RAD_W'(one_minus) << F;
  end

  // Square root chain, most significant root bit first.
  logic [RAD_W-1:0]  srem  [F+2];
  logic [ROOT_W-1:0] sroot [F+2];

  assign srem[0]  = rad_q;
  assign sroot[0] = '0;

  for (genvar k = 0; k <= F; k++) begin : g_sqrt
    lei_sqrt_cell #(.FRAC_BITS(F), .BIT_POS(F - k)) u_cell (
      .clk_i, .rem_i(srem[k]), .root_i(sroot[k]), .rem_o(srem[k+1]), .root_o(sroot[k+1])
    );
  end

  logic [ROOT_W-1:0] gamma_rcp;
  assign gamma_rcp = sroot[F+1];

  // Gamma divider: 2^(2F) / gamma_rcp, the single numerator one enters first.
  logic [ROOT_W-1:0] grem [GQ_W+1];
  logic [GQ_W-1:0]   gquo [GQ_W+1];
  logic [ROOT_W-1:0] gden [GQ_W+1];

  assign grem[0] = '0;
  assign gquo[0] = '0;
  assign gden[0] = gamma_rcp;

  for (genvar k = 0; k < GQ_W; k++) begin : g_gdiv
    lei_div_cell #(.DEN_W(ROOT_W), .QUO_W(GQ_W)) u_cell (
      .clk_i, .rem_i(grem[k]), .quo_i(gquo[k]), .den_i(gden[k]),
      .num_bit_i(k == 0), .rem_o(grem[k+1]), .quo_o(gquo[k+1]), .den_o(gden[k+1])
    );
  end

  logic [GX_W-1:0]   gq_ext;
  logic [DATA_W-1:0] gamma_q;

  assign gq_ext = GX_W'(gquo[GQ_W]);

  always_ff @(posedge clk_i) begin
    gamma_q <= (|gq_ext[GX_W-1:DATA_W-1]) ? SMAX : gq_ext[DATA_W-1:0];
  end

  // Operands that wait for gamma.
  logic [ROOT_W-1:0] gamma_rcp_late;
  logic [DATA_W-1:0] mass_late, ptime_late;

  lei_delay #(.WIDTH(ROOT_W), .DEPTH(ST_MUL - ST_ROOT)) u_ig_dly (
    .clk_i, .data_i(gamma_rcp), .data_o(gamma_rcp_late)
  );
  lei_delay #(.WIDTH(DATA_W), .DEPTH(ST_MUL)) u_mass_dly (
    .clk_i, .data_i(mass_q), .data_o(mass_late)
  );
  lei_delay #(.WIDTH(DATA_W), .DEPTH(ST_MUL)) u_ptime_dly (
    .clk_i, .data_i(ptime_q), .data_o(ptime_late)
  );

  lei_fxmac #(.FRAC_BITS(F)) u_ptime (
    .clk_i, .a_i(ts_q), .b_i(DATA_W'(gamma_rcp_late)), .addend_i(ptime_late),
    .sum_o(new_proper_time_o)
  );
  lei_fxmac #(.FRAC_BITS(F)) u_mass (
    .clk_i, .a_i(mass_late), .b_i(gamma_q), .addend_i('0), .sum_o(effective_mass_o)
  );

  // The divider remainder must start below c squared unless clamped.
  a_beta_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_PREP] |-> (clamp_q || (brem0_q < c2_q)))
    else $error("beta divider started with remainder not below c squared");

  // Beta squared is clamped, so the radicand is at least six scaled units.
  a_radicand_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_RAD] |-> (rad_q >= (RAD_W'(6) << F)))
    else $error("root radicand below the clamp floor");

  // The inverse gamma feeding the reciprocal is nonzero and at most one.
  a_inv_gamma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_ROOT] |-> ((gamma_rcp != '0) && (gamma_rcp <= ONE_RAW)))
    else $error("inverse gamma out of range");

endmodule

@@ sv/lei_delay.sv @@
// Plain shift line that moves a word forward one register per cycle.
// Depends on nothing; used for payload that rides along the cell chains.
module lei_delay #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= data_i;
    for (int k = 1; k < DEPTH; k++) begin
      tap_q[k] <= tap_q[k-1];
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

@@ sv/lei_fxmac.sv @@
// Signed fixed-point multiply with truncation toward zero, saturation and a
// saturating add of a third operand; four register stages. Uses lei_pkg.
module lei_fxmac #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                                clk_i,
  input  logic [lei_pkg::DATA_W-1:0]          a_i,
  input  logic [lei_pkg::DATA_W-1:0]          b_i,
  input  logic [lei_pkg::DATA_W-1:0]          addend_i,
  output logic [lei_pkg::DATA_W-1:0]          sum_o
);
  import lei_pkg::*;

  logic [31:0]         a_lo, a_hi, b_lo, b_hi;
  logic [DATA_W-1:0]   mag_a, mag_b;
  logic [63:0]         pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic [127:0]        prod_d, prod_q;
  logic                neg1_q, neg2_q;
  logic [DATA_W-1:0]   add1_q, add2_q, add3_q;
  logic [DATA_W-1:0]   cap, trunc, mag_m, prod_val_d, prod_val_q;
  logic                ovf;
  logic [DATA_W-1:0]   sum_raw, sum_d, sum_q;

  assign mag_a = a_i[DATA_W-1] ? (DATA_W'(0) - a_i) : a_i;
  assign mag_b = b_i[DATA_W-1] ? (DATA_W'(0) - b_i) : b_i;
  assign a_lo  = mag_a[31:0];
  assign a_hi  = mag_a[63:32];
  assign b_lo  = mag_b[31:0];
  assign b_hi  = mag_b[63:32];

  always_ff @(posedge clk_i) begin
    pp_ll_q <= 64'(a_lo) * 64'(b_lo);
    pp_lh_q <= 64'(a_lo) * 64'(b_hi);
    pp_hl_q <= 64'(a_hi) * 64'(b_lo);
    pp_hh_q <= 64'(a_hi) * 64'(b_hi);
    neg1_q  <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
    add1_q  <= addend_i;
  end

  assign prod_d = {pp_hh_q, 64'd0} + (128'(pp_lh_q) << 32) + (128'(pp_hl_q) << 32)
                  + 128'(pp_ll_q);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg2_q <= neg1_q;
    add2_q <= add1_q;
  end

  // Drop the fraction bits; anything left above 64 bits is an overflow.
  assign cap        = neg2_q ? SMIN : SMAX;
  assign ovf        = |prod_q[127:FRAC_BITS+64];
  assign trunc      = prod_q[FRAC_BITS+63:FRAC_BITS];
  assign mag_m      = (ovf || (trunc > cap)) ? cap : trunc;
  assign prod_val_d = neg2_q ? (DATA_W'(0) - mag_m) : mag_m;

  always_ff @(posedge clk_i) begin
    prod_val_q <= prod_val_d;
    add3_q     <= add2_q;
  end

  assign sum_raw = prod_val_q + add3_q;
  always_comb begin
    sum_d = sum_raw;
    if ((prod_val_q[DATA_W-1] == add3_q[DATA_W-1]) &&
        (sum_raw[DATA_W-1] != add3_q[DATA_W-1])) begin
      sum_d = add3_q[DATA_W-1] ? SMIN : SMAX;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

@@ sv/lei_div_cell.sv @@
// One restoring division step: shifts a numerator bit into the partial
// remainder, subtracts the divisor when it fits and appends the quotient bit.
module lei_div_cell #(
  parameter int unsigned DEN_W = 63,
  parameter int unsigned QUO_W = 32
) (
  input  logic             clk_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [QUO_W-1:0] quo_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic             num_bit_i,
  output logic [DEN_W-1:0] rem_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [DEN_W-1:0] den_o
);

  logic [DEN_W:0]   shifted, diff;
  logic             fits;
  logic [DEN_W-1:0] rem_d, rem_q, den_q;
  logic [QUO_W-1:0] quo_d, quo_q;

  assign shifted = {rem_i, num_bit_i};
  assign diff    = shifted - {1'b0, den_i};
  assign fits    = shifted >= {1'b0, den_i};
  assign rem_d   = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  assign quo_d   = {quo_i[QUO_W-2:0], fits};

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_i;
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign den_o = den_q;

endmodule

@@ sv/lei_sqrt_cell.sv @@
// One digit of a truncating square root: tries to set root bit BIT_POS,
// keeping the remainder (radicand minus root squared) along the chain.
module lei_sqrt_cell #(
  parameter int unsigned FRAC_BITS = 32,
  parameter int unsigned BIT_POS   = 0
) (
  input  logic                   clk_i,
  input  logic [2*FRAC_BITS+1:0] rem_i,
  input  logic [FRAC_BITS:0]     root_i,
  output logic [2*FRAC_BITS+1:0] rem_o,
  output logic [FRAC_BITS:0]     root_o
);

  localparam int unsigned REM_W = 2 * FRAC_BITS + 2;

  logic [REM_W-1:0]   trial, rem_d, rem_q;
  logic [FRAC_BITS:0] root_d, root_q;
  logic               fits;

  // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
  assign trial  = (REM_W'(root_i) << (BIT_POS + 1)) + (REM_W'(1) << (2 * BIT_POS));
  assign fits   = rem_i >= trial;
  assign rem_d  = fits ? (rem_i - trial) : rem_i;
  assign root_d = fits ? (root_i | ((FRAC_BITS+1)'(1) << BIT_POS)) : root_i;

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule
